[sv/fslc_pkg.sv]
// ----------------------------------------------------------------------------
// fslc_pkg
// Shared types, constants and the size clamp for the font slot LRU cache.
// ----------------------------------------------------------------------------
package fslc_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int STAMP_BITS  = 32;
  localparam int FAMILY_BITS = 16;
  localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
  localparam int SIZE_W      = 8;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  localparam logic REG_DEFAULT_SIZE = 1'b0;
  localparam logic REG_MAX_SIZE     = 1'b1;

  localparam logic [SIZE_W-1:0] DEFAULT_SIZE_RST = 8'd16;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST     = 8'd192;

  typedef logic [SLOT_IDX_W-1:0]  slot_idx_t;
  typedef logic [STAMP_BITS-1:0]  stamp_t;
  typedef logic [FAMILY_BITS-1:0] family_t;
  typedef logic [SIZE_W-1:0]      size_t;

  typedef struct packed {
    family_t family;
    size_t   size;
    stamp_t  stamp;
  } slot_entry_t;

  typedef struct packed {
    logic      clear;
    logic      valid;
    logic      built;
    slot_idx_t idx;
  } scan_ctl_t;

  typedef struct packed {
    logic      empty_found;
    slot_idx_t empty_idx;
    slot_idx_t lru_idx;
  } scan_res_t;

  function automatic size_t clamp_size(logic [10:0] raw, size_t dflt, size_t max_sz);
    logic [10:0] s;
    s = (raw != 11'd0 && !raw[10]) ? raw : {3'b000, dflt};
    if (s > {3'b000, max_sz}) s = {3'b000, max_sz};
    if (s == 11'd0) s = 11'd1;
    return s[SIZE_W-1:0];
  endfunction

endpackage

[sv/fslc_slot_mem.sv]
// ----------------------------------------------------------------------------
// fslc_slot_mem
// Slot key and stamp memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fslc_slot_mem (
  input  logic                clk,
  input  logic                we,
  input  fslc_pkg::slot_idx_t waddr,
  input  fslc_pkg::slot_entry_t wdata,
  input  logic                re,
  input  fslc_pkg::slot_idx_t raddr,
  output fslc_pkg::slot_entry_t rdata
);

  fslc_pkg::slot_entry_t mem [fslc_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/fslc_scan_unit.sv]
// ----------------------------------------------------------------------------
// fslc_scan_unit
// Shared compare unit: key match, first free slot and oldest stamp tracking.
// ----------------------------------------------------------------------------
module fslc_scan_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  fslc_pkg::scan_ctl_t   ctl,
  input  fslc_pkg::slot_entry_t entry,
  input  fslc_pkg::family_t     key_family,
  input  fslc_pkg::size_t       key_size,
  output logic                  match,
  output fslc_pkg::scan_res_t   res
);

  logic                empty_found;
  fslc_pkg::slot_idx_t empty_idx;
  fslc_pkg::slot_idx_t lru_idx;
  fslc_pkg::stamp_t    lru_stamp;

  assign match = ctl.valid && ctl.built && entry.family == key_family &&
                 entry.size == key_size;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      empty_found <= 1'b0;
    end else if (ctl.valid && !ctl.built && !empty_found) begin
      empty_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      if (!ctl.built && !empty_found) begin
        empty_idx <= ctl.idx;
      end
      if (ctl.idx == '0 || entry.stamp < lru_stamp) begin
        lru_idx   <= ctl.idx;
        lru_stamp <= entry.stamp;
      end
    end
  end

  assign res.empty_found = empty_found;
  assign res.empty_idx   = empty_idx;
  assign res.lru_idx     = lru_idx;

endmodule

[sv/font_slot_lru_cache_core.sv]
// ----------------------------------------------------------------------------
// font_slot_lru_cache_core
// Fully associative font slot cache with LRU replacement by use stamp.
// ----------------------------------------------------------------------------
// Build reports and rejected lookups: done in the cycle after accept, next
//   request may be accepted in that same cycle.
// Lookup: a hit ends the scan at the first matching slot; a miss scans every
//   slot and then allocates, one slot read per cycle from the slot memory read port.
// A miss keeps the block busy through the scan and the allocation.
// rst clears built/ready bits, registers to defaults and the use counter to 1.
module font_slot_lru_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic signed [15:0] family_id,
  input  logic signed [10:0] size_px,
  input  logic [5:0]  report_slot,
  input  logic        build_ok,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic        rejected,
  output logic        hit,
  output logic [5:0]  slot,
  output logic        ready_res,
  output logic        replaced
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;
  localparam int         CNT_W    = fslc_pkg::SLOT_IDX_W + 1;

  logic [1:0]                        state;
  fslc_pkg::size_t                   default_size;
  fslc_pkg::size_t                   max_size;
  logic [fslc_pkg::SLOT_COUNT-1:0]   slot_built;
  logic [fslc_pkg::SLOT_COUNT-1:0]   slot_ready;
  fslc_pkg::stamp_t                  use_counter;
  fslc_pkg::family_t                 key_family;
  fslc_pkg::size_t                   key_size;
  fslc_pkg::stamp_t                  now;
  logic [CNT_W-1:0]                  rd_cnt;
  logic                              cmp_vld;
  fslc_pkg::slot_idx_t               cmp_idx;

  logic                  accept;
  logic                  rd_en;
  logic                  match;
  logic                  mem_we;
  fslc_pkg::slot_idx_t   mem_waddr;
  fslc_pkg::slot_entry_t mem_wdata;
  fslc_pkg::slot_entry_t mem_rdata;
  fslc_pkg::scan_ctl_t   scan_ctl;
  fslc_pkg::scan_res_t   scan_res;
  fslc_pkg::slot_idx_t   chosen;
  fslc_pkg::slot_idx_t   rep_idx;
  logic                  rep_in_range;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;
  assign rd_en  = state == ST_SCAN && rd_cnt < CNT_W'(fslc_pkg::SLOT_COUNT);
  assign chosen = scan_res.empty_found ? scan_res.empty_idx : scan_res.lru_idx;
  assign rep_idx      = fslc_pkg::SLOT_IDX_W'(report_slot);
  assign rep_in_range = 32'(report_slot) < fslc_pkg::SLOT_COUNT;

  assign scan_ctl.clear = accept;
  assign scan_ctl.valid = cmp_vld && state == ST_SCAN;
  assign scan_ctl.built = slot_built[cmp_idx];
  assign scan_ctl.idx   = cmp_idx;

  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = cmp_idx;
    mem_wdata.family = key_family;
    mem_wdata.size   = key_size;
    mem_wdata.stamp  = now;
    if (state == ST_SCAN && match) begin
      mem_we = 1'b1;
    end else if (state == ST_ALLOC) begin
      mem_we    = 1'b1;
      mem_waddr = chosen;
    end
  end

  fslc_slot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_cnt[fslc_pkg::SLOT_IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  fslc_scan_unit u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .entry      (mem_rdata),
    .key_family (key_family),
    .key_size   (key_size),
    .match      (match),
    .res        (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_size <= fslc_pkg::DEFAULT_SIZE_RST;
      max_size     <= fslc_pkg::MAX_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        fslc_pkg::REG_DEFAULT_SIZE: default_size <= cfg_data;
        fslc_pkg::REG_MAX_SIZE:     max_size     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot_built  <= '0;
      slot_ready  <= '0;
      use_counter <= fslc_pkg::stamp_t'(1);
      cmp_vld     <= 1'b0;
      done        <= 1'b0;
    end else begin
      done    <= 1'b0;
      cmp_vld <= rd_en;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rejected  <= 1'b0;
            hit       <= 1'b0;
            replaced  <= 1'b0;
            ready_res <= 1'b0;
            slot      <= 6'd0;
            if (cmd == fslc_pkg::CMD_REPORT) begin
              done <= 1'b1;
              slot <= report_slot;
              if (rep_in_range) begin
                if (slot_built[rep_idx]) begin
                  slot_ready[rep_idx] <= build_ok;
                end
                ready_res <= slot_built[rep_idx] && build_ok;
              end
            end else if (family_id[15]) begin
              done     <= 1'b1;
              rejected <= 1'b1;
            end else begin
              key_family  <= fslc_pkg::FAMILY_BITS'($unsigned(family_id));
              key_size    <= fslc_pkg::clamp_size($unsigned(size_px), default_size,
                                                  max_size);
              now         <= use_counter;
              use_counter <= use_counter + fslc_pkg::stamp_t'(1);
              rd_cnt      <= '0;
              state       <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          cmp_idx <= rd_cnt[fslc_pkg::SLOT_IDX_W-1:0];
          if (cmp_vld) begin
            if (match) begin
              done      <= 1'b1;
              hit       <= 1'b1;
              slot      <= 6'(cmp_idx);
              ready_res <= slot_ready[cmp_idx];
              cmp_vld   <= 1'b0;
              state     <= ST_IDLE;
            end else if (cmp_idx == fslc_pkg::SLOT_IDX_W'(fslc_pkg::SLOT_COUNT - 1)) begin
              state <= ST_ALLOC;
            end
          end
        end
        ST_ALLOC: begin
          done               <= 1'b1;
          slot               <= 6'(chosen);
          replaced           <= slot_built[chosen];
          slot_built[chosen] <= 1'b1;
          slot_ready[chosen] <= 1'b0;
          cmp_vld            <= 1'b0;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hit_not_replaced: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && replaced))
    else $error("hit and replaced both set");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && rejected) |-> (!hit && !replaced && !ready_res && slot == 6'd0))
    else $error("rejected request carries result fields");

  a_alloc_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_ALLOC |=> (done && !hit && state == ST_IDLE))
    else $error("allocation did not complete");

  a_report_done: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == fslc_pkg::CMD_REPORT) |=> (done && !hit && !rejected))
    else $error("build report gave no result");
`endif

endmodule

[dv/font_slot_lru_cache_core_test.sv]
// ----------------------------------------------------------------------------
// font_slot_lru_cache_core_test
// Self-checking bench for the font slot LRU cache core. A scoreboard keeps
// its own copy of the slot table, the use counter and the size registers.
// It predicts each result from the accepted requests and compares the
// results that the core strobes out, in order. Directed requests come
// first, then random phases under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module font_slot_lru_cache_core_test;

  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic                rejected;
    logic                hit;
    fslc_pkg::slot_idx_t slot;
    logic                ready_res;
    logic                replaced;
  } slot_result_t;

  class font_cache_scoreboard;
    fslc_pkg::size_t     dflt_size;
    fslc_pkg::size_t     size_limit;
    logic                built [fslc_pkg::SLOT_COUNT];
    logic                ready [fslc_pkg::SLOT_COUNT];
    fslc_pkg::family_t   fam_key [fslc_pkg::SLOT_COUNT];
    fslc_pkg::size_t     size_key [fslc_pkg::SLOT_COUNT];
    fslc_pkg::stamp_t    stamp [fslc_pkg::SLOT_COUNT];
    fslc_pkg::stamp_t    use_count;
    fslc_pkg::slot_idx_t last_slot;
    slot_result_t        pending [$];
    int                  mismatches;

    function new();
      dflt_size  = fslc_pkg::DEFAULT_SIZE_RST;
      size_limit = fslc_pkg::MAX_SIZE_RST;
      for (int i = 0; i < fslc_pkg::SLOT_COUNT; i++) begin
        built[i]    = 1'b0;
        ready[i]    = 1'b0;
        fam_key[i]  = '1;
        size_key[i] = '0;
        stamp[i]    = '0;
      end
      use_count  = 1;
      last_slot  = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic idx, fslc_pkg::size_t value);
      if (idx == fslc_pkg::REG_DEFAULT_SIZE) dflt_size = value;
      else size_limit = value;
    endfunction

    function fslc_pkg::size_t clamped(logic signed [10:0] raw);
      int s;
      s = (raw > 0) ? int'(raw) : int'(dflt_size);
      if (s > int'(size_limit)) s = int'(size_limit);
      if (s < 1) s = 1;
      return fslc_pkg::size_t'(s);
    endfunction

    function void note_request(logic c, logic signed [15:0] fam, logic signed [10:0] sz,
                               fslc_pkg::slot_idx_t rep, logic ok);
      slot_result_t     r;
      fslc_pkg::stamp_t now;
      fslc_pkg::size_t  key_size;
      int               empty_slot;
      int               lru_slot;
      int               chosen;
      r = '0;
      if (c == fslc_pkg::CMD_REPORT) begin
        r.slot = rep;
        if (built[rep]) ready[rep] = ok;
        r.ready_res = ready[rep];
      end else if (fam[15]) begin
        r.rejected = 1'b1;
      end else begin
        key_size   = clamped(sz);
        now        = use_count;
        use_count  = use_count + 1;
        empty_slot = -1;
        lru_slot   = 0;
        for (int i = 0; i < fslc_pkg::SLOT_COUNT && !r.hit; i++) begin
          if (built[i] && fam_key[i] == fslc_pkg::family_t'(fam) &&
              size_key[i] == key_size) begin
            stamp[i]    = now;
            r.hit       = 1'b1;
            r.slot      = fslc_pkg::slot_idx_t'(i);
            r.ready_res = ready[i];
          end else begin
            if (!built[i] && empty_slot < 0) empty_slot = i;
            if (stamp[i] < stamp[lru_slot]) lru_slot = i;
          end
        end
        if (!r.hit) begin
          chosen           = (empty_slot >= 0) ? empty_slot : lru_slot;
          r.replaced       = built[chosen];
          built[chosen]    = 1'b1;
          ready[chosen]    = 1'b0;
          fam_key[chosen]  = fslc_pkg::family_t'(fam);
          size_key[chosen] = key_size;
          stamp[chosen]    = now;
          r.slot           = fslc_pkg::slot_idx_t'(chosen);
        end
        last_slot = r.slot;
      end
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      if (pending.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
      compare_field("hit", 8'(want.hit), 8'(got.hit));
      compare_field("slot", 8'(want.slot), 8'(got.slot));
      compare_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
      compare_field("replaced", 8'(want.replaced), 8'(got.replaced));
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd = fslc_pkg::CMD_LOOKUP;
  logic signed [15:0] family_id = '0;
  logic signed [10:0] size_px = '0;
  logic [5:0]        report_slot = '0;
  logic              build_ok = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = fslc_pkg::REG_DEFAULT_SIZE;
  logic [7:0]        cfg_data = '0;
  logic              done;
  logic              rejected;
  logic              hit;
  logic [5:0]        slot;
  logic              ready_res;
  logic              replaced;

  font_cache_scoreboard sb;
  int                   quiet_cycles = 0;

  font_slot_lru_cache_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result({rejected, hit, slot, ready_res, replaced});
      if (cfg_we) sb.write_register(cfg_idx, cfg_data);
      if (start && !busy) sb.note_request(cmd, family_id, size_px, report_slot, build_ok);
      if (done || (start && !busy) || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // start stays high between back-to-back requests
  task automatic send_request(int gap, logic c, logic signed [15:0] fam,
                              logic signed [10:0] sz, fslc_pkg::slot_idx_t rep, logic ok);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd         <= c;
    family_id   <= fam;
    size_px     <= sz;
    report_slot <= rep;
    build_ok    <= ok;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_settings(fslc_pkg::size_t dflt, fslc_pkg::size_t limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= fslc_pkg::REG_DEFAULT_SIZE;
    cfg_data <= dflt;
    @(posedge clk);
    cfg_idx  <= fslc_pkg::REG_MAX_SIZE;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request(int idle_pct);
    int unsigned         roll;
    int                  gap;
    logic                c;
    logic signed [15:0]  fam;
    logic signed [10:0]  sz;
    fslc_pkg::slot_idx_t rep;
    logic                ok;
    gap = 0;
    if (idle_pct > 0) begin
      if ($urandom_range(15) == 0) gap = $urandom_range(1, 80);
      else while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    end
    if ($urandom_range(59) == 0) wait_idle();
    c    = fslc_pkg::CMD_LOOKUP;
    fam  = 16'($urandom);
    sz   = 11'($urandom);
    rep  = 6'($urandom);
    ok   = 1'($urandom);
    roll = $urandom_range(99);
    if (roll < 25) begin
      c = fslc_pkg::CMD_REPORT;
      if ($urandom_range(1) == 0) rep = sb.last_slot;
    end else if (roll < 92) begin
      fam = 16'($urandom_range(7));
      case ($urandom_range(3))
        0: sz = 11'($urandom_range(248, 255));
        1: sz = 11'(-int'($urandom_range(2)));
        default: sz = 11'($urandom_range(1, 8));
      endcase
    end
    send_request(gap, c, fam, sz, rep, ok);
  endtask

  initial begin
    fslc_pkg::size_t dflt;
    fslc_pkg::size_t limit;
    int              idle_pct;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed, reset settings: default 16, max 192
    send_request(0, fslc_pkg::CMD_REPORT, 0, 0, 0, 1'b1);
    send_request(0, fslc_pkg::CMD_LOOKUP, 0, 0, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 0, 16, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_REPORT, 0, 0, 0, 1'b1);
    send_request(0, fslc_pkg::CMD_LOOKUP, 0, -1024, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 32767, 1023, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 32767, 192, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 32767, 193, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, -32768, 5, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, -1, -1, 63, 1'b1);
    send_request(0, fslc_pkg::CMD_REPORT, -1, 1023, 63, 1'b1);
    send_request(0, fslc_pkg::CMD_REPORT, 0, 0, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 0, 16, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_REPORT, 0, 0, 1, 1'b1);
    send_request(0, fslc_pkg::CMD_LOOKUP, 32767, 191, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 0, 1, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_REPORT, 0, 0, 2, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 21845, 682, 0, 1'b0);
    send_request(0, fslc_pkg::CMD_LOOKUP, 10922, 341, 0, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin dflt = 16;  limit = 192; idle_pct = 0;  end
        1: begin dflt = 1;   limit = 1;   idle_pct = 58; end
        2: begin dflt = 255; limit = 255; idle_pct = 8;  end
        3: begin dflt = 255; limit = 1;   idle_pct = 0;  end
        4: begin dflt = 1;   limit = 255; idle_pct = 58; end
        default: begin
          dflt     = 8'($urandom_range(1, 255));
          limit    = 8'($urandom_range(1, 255));
          idle_pct = (ph == 5) ? 8 : 58;
        end
      endcase
      wait_idle();
      write_settings(dflt, limit);
      for (int n = 0; n < 100; n++) random_request(idle_pct);
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
sv/fslc_pkg.sv
sv/fslc_slot_mem.sv
sv/fslc_scan_unit.sv
sv/font_slot_lru_cache_core.sv
dv/font_slot_lru_cache_core_test.sv
